// ===== src/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
// Depends on nothing; used by every file under src.
package hsv2rgb_pkg;

   localparam int COLOR_BITS   = 8;
   localparam int HUE_BITS     = 13;
   localparam int SECTOR_UNITS = 960;
   localparam int HUE_PERIOD   = 2 * SECTOR_UNITS;
   localparam int PHASE_BITS   = $clog2(HUE_PERIOD);
   localparam int WEIGHT_BITS  = $clog2(SECTOR_UNITS + 1);

   // accept edge to result strobe, in clock cycles
   localparam int CONV_LATENCY = 4;

   localparam int CHROMA_BITS   = 2 * COLOR_BITS;
   localparam int MID_PROD_BITS = CHROMA_BITS + WEIGHT_BITS;

   localparam longint FULL_SCALE = (64'd1 << COLOR_BITS) - 64'd1;
   localparam longint MID_DEN    = SECTOR_UNITS * FULL_SCALE;
   localparam int     MID_DEN_BITS = $clog2(MID_DEN);

   // reciprocal for the bottom level: floor(y / F), y < 2^(2*COLOR_BITS)
   localparam int     BOT_SHIFT      = CHROMA_BITS;
   localparam longint BOT_RECIP      = (64'd1 << BOT_SHIFT) / FULL_SCALE;
   localparam int     BOT_RECIP_BITS = COLOR_BITS + 1;
   localparam int     BOT_PROD_BITS  = CHROMA_BITS + BOT_RECIP_BITS;

   // reciprocal for the middle level: floor(y / (960 * F))
   localparam int     MID_SHIFT      = MID_PROD_BITS + 8;
   localparam longint MID_RECIP      = (64'd1 << MID_SHIFT) / MID_DEN;
   localparam int     MID_RECIP_BITS = MID_SHIFT - MID_DEN_BITS + 1;
   localparam int     MQ_PROD_BITS   = MID_PROD_BITS + MID_RECIP_BITS;

   typedef enum logic [2:0] {
      SECTOR_RED_UP    = 3'd0,
      SECTOR_GREEN_DN  = 3'd1,
      SECTOR_GREEN_UP  = 3'd2,
      SECTOR_BLUE_DN   = 3'd3,
      SECTOR_BLUE_UP   = 3'd4,
      SECTOR_RED_DN    = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]   hue;
      logic [COLOR_BITS-1:0] saturation;
      logic [COLOR_BITS-1:0] brightness;
   } pixel_hsv_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } pixel_rgb_type;

   // sector plus the weight 960 - f that scales chroma for the middle level
   typedef struct packed {
      sector_type             sector;
      logic [WEIGHT_BITS-1:0] weight;
   } hue_info_type;

endpackage

// ===== src/hsv2rgb_hue_decode.sv =====
// Hue decode: sector select and triangle weight from the hue angle.
// Depends on hsv2rgb_pkg.
module hsv2rgb_hue_decode (
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0] hue,
   output hsv2rgb_pkg::hue_info_type        info
);
   import hsv2rgb_pkg::*;

   logic [HUE_BITS-1:0]    base;
   logic [HUE_BITS-1:0]    phase_full;
   logic [PHASE_BITS-1:0]  phase;
   logic [WEIGHT_BITS-1:0] tri_f;

   // hue mod 1920 by picking the largest period multiple at or below hue
   always_comb begin
      if (hue >= HUE_BITS'(4 * HUE_PERIOD)) begin
         base = HUE_BITS'(4 * HUE_PERIOD);
      end else if (hue >= HUE_BITS'(3 * HUE_PERIOD)) begin
         base = HUE_BITS'(3 * HUE_PERIOD);
      end else if (hue >= HUE_BITS'(2 * HUE_PERIOD)) begin
         base = HUE_BITS'(2 * HUE_PERIOD);
      end else if (hue >= HUE_BITS'(HUE_PERIOD)) begin
         base = HUE_BITS'(HUE_PERIOD);
      end else begin
         base = '0;
      end
      phase_full = hue - base;
      phase      = phase_full[PHASE_BITS-1:0];
      if (phase <= PHASE_BITS'(SECTOR_UNITS)) begin
         tri_f = WEIGHT_BITS'(phase);
      end else begin
         tri_f = WEIGHT_BITS'(PHASE_BITS'(HUE_PERIOD) - phase);
      end
      info.weight = WEIGHT_BITS'(SECTOR_UNITS) - tri_f;

      if (hue < HUE_BITS'(SECTOR_UNITS)) begin
         info.sector = SECTOR_RED_UP;
      end else if (hue < HUE_BITS'(2 * SECTOR_UNITS)) begin
         info.sector = SECTOR_GREEN_DN;
      end else if (hue < HUE_BITS'(3 * SECTOR_UNITS)) begin
         info.sector = SECTOR_GREEN_UP;
      end else if (hue < HUE_BITS'(4 * SECTOR_UNITS)) begin
         info.sector = SECTOR_BLUE_DN;
      end else if (hue < HUE_BITS'(5 * SECTOR_UNITS)) begin
         info.sector = SECTOR_BLUE_UP;
      end else begin
         info.sector = SECTOR_RED_DN;
      end
   end

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// rsp_valid is high while the result register holds an accepted transaction's pixel.
// Throughput: one transaction per clock; busy is always low, as the receiver cannot stall.
// The pipeline has four register stages: hue decode and v*s, the chroma products,
// the reciprocal multiply for the middle level, and its remainder correction.
// Reset (synchronous, active high) clears the stage valid bits; payload stages are not reset.
// Depends on hsv2rgb_pkg and hsv2rgb_hue_decode.
module hsv_to_rgb_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hsv2rgb_pkg::pixel_hsv_type req_pixel,
   output logic                       rsp_valid,
   output hsv2rgb_pkg::pixel_rgb_type rsp_pixel
);
   import hsv2rgb_pkg::*;

   // stage valid bits: [0] stage 1 ... [CONV_LATENCY-1] result register
   logic [CONV_LATENCY-1:0] valid_ff, valid_in;
   logic                    accept;

   // ---- stage 1: hue decode, chroma product v*s
   hue_info_type            info_in, info1_ff;
   logic [CHROMA_BITS-1:0]  vs_in, vs1_ff;
   logic [COLOR_BITS-1:0]   v1_ff;

   // ---- stage 2: bottom reciprocal estimate, middle numerator
   logic [CHROMA_BITS-1:0]   ybot_in, ybot2_ff;
   logic [BOT_PROD_BITS-1:0] bot_prod;
   logic [COLOR_BITS-1:0]    bq0_in, bq0_2_ff;
   logic [MID_PROD_BITS-1:0] mprod_in, mprod2_ff;
   logic [COLOR_BITS-1:0]    v2_ff;
   sector_type               sector2_ff;

   // ---- stage 3: bottom level done, middle reciprocal estimate
   logic [MID_PROD_BITS-1:0] ymid_in, ymid3_ff;
   logic [MQ_PROD_BITS-1:0]  mq_prod;
   logic [COLOR_BITS-1:0]    mq0_in, mq0_3_ff;
   logic [CHROMA_BITS-1:0]   brem;
   logic [COLOR_BITS-1:0]    bq;
   logic [COLOR_BITS-1:0]    bot_in, bot3_ff;
   logic [COLOR_BITS-1:0]    v3_ff;
   sector_type               sector3_ff;

   // ---- stage 4: middle correction and channel permutation
   logic [MID_PROD_BITS-1:0] mrem;
   logic [COLOR_BITS-1:0]    mq;
   logic [COLOR_BITS-1:0]    mid;
   pixel_rgb_type            rsp_in, rsp_ff;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[CONV_LATENCY-2:0], accept};

   hsv2rgb_hue_decode u_hue_decode (
      .hue  (req_pixel.hue),
      .info (info_in)
   );

   assign vs_in = CHROMA_BITS'(req_pixel.brightness) * CHROMA_BITS'(req_pixel.saturation);

   // bottom = v - ceil(vs/F); ceil via +F-1, quotient via reciprocal, low by at most one
   assign ybot_in  = vs1_ff + CHROMA_BITS'(FULL_SCALE - 64'd1);
   assign bot_prod = BOT_PROD_BITS'(ybot_in) * BOT_PROD_BITS'(BOT_RECIP);
   assign bq0_in   = bot_prod[BOT_SHIFT +: COLOR_BITS];
   assign mprod_in = MID_PROD_BITS'(vs1_ff) * MID_PROD_BITS'(info1_ff.weight);

   assign brem   = ybot2_ff - CHROMA_BITS'(bq0_2_ff) * CHROMA_BITS'(FULL_SCALE);
   assign bq     = bq0_2_ff + COLOR_BITS'(brem >= CHROMA_BITS'(FULL_SCALE));
   assign bot_in = v2_ff - bq;

   // middle = v - ceil(vs*weight / (960*F)), same estimate-and-correct scheme
   assign ymid_in = mprod2_ff + MID_PROD_BITS'(MID_DEN - 64'd1);
   assign mq_prod = MQ_PROD_BITS'(ymid_in) * MQ_PROD_BITS'(MID_RECIP);
   assign mq0_in  = mq_prod[MID_SHIFT +: COLOR_BITS];

   assign mrem = ymid3_ff - MID_PROD_BITS'(mq0_3_ff) * MID_PROD_BITS'(MID_DEN);
   assign mq   = mq0_3_ff + COLOR_BITS'(mrem >= MID_PROD_BITS'(MID_DEN));
   assign mid  = v3_ff - mq;

   // top is v itself; the sector places top, middle and bottom
   always_comb begin
      case (sector3_ff)
         SECTOR_RED_UP:   rsp_in = '{red: v3_ff,   green: mid,     blue: bot3_ff};
         SECTOR_GREEN_DN: rsp_in = '{red: mid,     green: v3_ff,   blue: bot3_ff};
         SECTOR_GREEN_UP: rsp_in = '{red: bot3_ff, green: v3_ff,   blue: mid};
         SECTOR_BLUE_DN:  rsp_in = '{red: bot3_ff, green: mid,     blue: v3_ff};
         SECTOR_BLUE_UP:  rsp_in = '{red: mid,     green: bot3_ff, blue: v3_ff};
         SECTOR_RED_DN:   rsp_in = '{red: v3_ff,   green: bot3_ff, blue: mid};
         default:         rsp_in = '{red: v3_ff,   green: bot3_ff, blue: mid};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload moves every cycle; the valid bits mark live transactions
   always_ff @(posedge clock) begin
      info1_ff   <= info_in;
      vs1_ff     <= vs_in;
      v1_ff      <= req_pixel.brightness;

      ybot2_ff   <= ybot_in;
      bq0_2_ff   <= bq0_in;
      mprod2_ff  <= mprod_in;
      v2_ff      <= v1_ff;
      sector2_ff <= info1_ff.sector;

      ymid3_ff   <= ymid_in;
      mq0_3_ff   <= mq0_in;
      bot3_ff    <= bot_in;
      v3_ff      <= v2_ff;
      sector3_ff <= sector2_ff;

      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = valid_ff[CONV_LATENCY-1];
   assign rsp_pixel = rsp_ff;

endmodule

// ===== src/hsv2rgb_checker.sv =====
// Port-level checks for hsv_to_rgb_converter, attached by bind.
// Depends on hsv2rgb_pkg and the converter's port list.
module hsv2rgb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input hsv2rgb_pkg::pixel_hsv_type req_pixel,
   input logic                       rsp_valid,
   input hsv2rgb_pkg::pixel_rgb_type rsp_pixel
);
   import hsv2rgb_pkg::*;

   // every accepted transaction gives a strobe after the fixed latency
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##CONV_LATENCY rsp_valid)
      else $error("missing result strobe");

   // no strobe without a matching transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, CONV_LATENCY))
      else $error("result strobe without transaction");

   // zero saturation gives gray at the brightness level
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_pixel.saturation == '0) |-> ##CONV_LATENCY
      (rsp_pixel.red == $past(req_pixel.brightness, CONV_LATENCY) &&
       rsp_pixel.green == $past(req_pixel.brightness, CONV_LATENCY) &&
       rsp_pixel.blue == $past(req_pixel.brightness, CONV_LATENCY)))
      else $error("gray pixel mismatch");

   // hue zero at full saturation is pure red at the brightness level
   a_pure_red: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_pixel.hue == '0 && req_pixel.saturation == '1)
      |-> ##CONV_LATENCY
      (rsp_pixel.red == $past(req_pixel.brightness, CONV_LATENCY) &&
       rsp_pixel.green == '0 && rsp_pixel.blue == '0))
      else $error("pure red mismatch");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
